// File: design/lnc_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// name cache. No dependencies.
package lnc_pkg;

    localparam int ENTRIES     = 20;
    localparam int KEY_WORDS   = 4;
    localparam int VALUE_WORDS = 4;

    localparam int KMAX    = (KEY_WORDS > VALUE_WORDS) ? KEY_WORDS : VALUE_WORDS;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int K_W     = $clog2(KMAX + 1);
    localparam int KADDR_W = $clog2(ENTRIES * KEY_WORDS);
    localparam int VADDR_W = $clog2(ENTRIES * VALUE_WORDS);
    localparam int LEN_W   = $clog2(VALUE_WORDS * 8 + 1);
    localparam int SUM_W   = 13;
    localparam int MC_W    = 7;
    localparam int MC_MAX  = 64;
    localparam int MC_RESET = 33;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_KEY   = 2'd0;
    localparam kind_t KIND_FILL  = 2'd1;
    localparam kind_t KIND_CLEAR = 2'd2;

    typedef logic [1:0] res_t;
    localparam res_t RES_HIT  = 2'd0;
    localparam res_t RES_MISS = 2'd1;
    localparam res_t RES_ACK  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISPATCH, ST_SCAN, ST_KRD, ST_KCK, ST_VRD, ST_VCK,
        ST_ERD, ST_EMIT, ST_MISS, ST_ACK, ST_VICT, ST_WRITE
    } state_t;

    typedef struct packed {
        logic take;
        logic idx_rst;
        logic idx_inc;
        logic k_rst;
        logic k_inc;
        logic len_rst;
        logic len_acc;
        logic promote;
        logic emit_hit;
        logic emit_miss;
        logic emit_ack;
        logic write_word;
        logic commit;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  last;
        logic  key_tl;
        logic  fill_ok;
        logic  cand;
        logic  idx_last;
        logic  key_eq;
        logic  k_last_key;
        logic  k_last_val;
        logic  k_last_emit;
        logic  k_last_wr;
        logic  rank_oldest;
        logic  out_free;
    } sts_t;

endpackage

// File: design/lnc_ctrl.sv
// Sequencing state machine of the name cache.
// Depends on lnc_pkg; drives lnc_dp through cmd_t, reads sts_t.
module lnc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  lnc_pkg::sts_t sts,
    output lnc_pkg::cmd_t cmd
);
    import lnc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                if (sts.kind == KIND_KEY && sts.last) begin
                    state_next = sts.key_tl ? ST_MISS : ST_SCAN;
                end else if (sts.kind == KIND_FILL && sts.last) begin
                    state_next = sts.fill_ok ? ST_VICT : ST_ACK;
                end else if (sts.kind == KIND_CLEAR) begin
                    state_next = ST_ACK;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (sts.cand) state_next = ST_KRD;
                else if (sts.idx_last) state_next = ST_MISS;
            end
            ST_KRD: state_next = ST_KCK;
            ST_KCK: begin
                if (!sts.key_eq) state_next = sts.idx_last ? ST_MISS : ST_SCAN;
                else if (sts.k_last_key) state_next = ST_VRD;
                else state_next = ST_KRD;
            end
            ST_VRD: state_next = ST_VCK;
            ST_VCK: state_next = sts.k_last_val ? ST_ERD : ST_VRD;
            ST_ERD: state_next = ST_EMIT;
            ST_EMIT: begin
                if (sts.out_free) state_next = sts.k_last_emit ? ST_IDLE : ST_ERD;
            end
            ST_MISS: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            ST_ACK: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            ST_VICT: begin
                if (sts.rank_oldest || sts.idx_last) state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (sts.k_last_wr) state_next = ST_ACK;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            ST_DISPATCH: begin
                cmd.idx_rst = 1'b1;
            end
            ST_SCAN: begin
                cmd.k_rst   = sts.cand;
                cmd.idx_inc = !sts.cand && !sts.idx_last;
            end
            ST_KRD: begin
            end
            ST_KCK: begin
                cmd.idx_inc = !sts.key_eq && !sts.idx_last;
                cmd.k_inc   = sts.key_eq && !sts.k_last_key;
                cmd.k_rst   = sts.key_eq && sts.k_last_key;
                cmd.len_rst = sts.key_eq && sts.k_last_key;
                cmd.promote = sts.key_eq && sts.k_last_key;
            end
            ST_VRD: begin
            end
            ST_VCK: begin
                cmd.len_acc = 1'b1;
                cmd.k_rst   = sts.k_last_val;
                cmd.k_inc   = !sts.k_last_val;
            end
            ST_ERD: begin
            end
            ST_EMIT: begin
                cmd.emit_hit = sts.out_free;
                cmd.k_inc    = sts.out_free && !sts.k_last_emit;
            end
            ST_MISS: begin
                cmd.emit_miss = sts.out_free;
            end
            ST_ACK: begin
                cmd.emit_ack = sts.out_free;
            end
            ST_VICT: begin
                cmd.k_rst   = sts.rank_oldest || sts.idx_last;
                cmd.idx_inc = !(sts.rank_oldest || sts.idx_last);
            end
            ST_WRITE: begin
                cmd.write_word = 1'b1;
                cmd.k_inc      = !sts.k_last_wr;
                cmd.commit     = sts.k_last_wr;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: design/lnc_dp.sv
// Datapath of the name cache: string buffers, entry tags, recency ranks,
// key and value memories, counters and the result register. Depends on lnc_pkg.
module lnc_dp (
    input  logic          aclk,
    input  logic          aresetn,
    input  lnc_pkg::cmd_t cmd,
    output lnc_pkg::sts_t sts,
    input  logic [63:0]   s_tdata,
    input  logic [1:0]    s_tuser,
    input  logic          s_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [71:0]   m_tdata,
    output logic [1:0]    m_tuser,
    output logic          m_tlast,
    input  logic          cfg_we,
    input  logic [6:0]    cfg_data
);
    import lnc_pkg::*;

    // count of leading nonzero bytes, 8 when none is zero
    function automatic logic [3:0] first_zero(input logic [63:0] w);
        logic [3:0] n;
        logic       seen;
        n    = 4'd8;
        seen = 1'b0;
        for (int b = 0; b < 8; b++) begin
            if (!seen && w[8*b +: 8] == 8'd0) begin
                n    = 4'(b);
                seen = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [63:0] keep_bytes(input logic [63:0] w,
                                               input logic [7:0] nb);
        logic [63:0] r;
        r = '0;
        for (int b = 0; b < 8; b++) begin
            if (8'(b) < nb) r[8*b +: 8] = w[8*b +: 8];
        end
        return r;
    endfunction

    kind_t kind_reg, kind_next;
    logic  last_reg, last_next;

    logic [63:0]    key_buf_reg [KEY_WORDS];
    logic [63:0]    key_buf_next [KEY_WORDS];
    logic [K_W-1:0] key_cnt_reg, key_cnt_next;
    logic           key_end_reg, key_end_next;
    logic           key_tl_reg, key_tl_next;
    logic           key_cmp_reg, key_cmp_next;
    logic [SUM_W-1:0] sum_reg, sum_next;

    logic [63:0]    val_buf_reg [VALUE_WORDS];
    logic [63:0]    val_buf_next [VALUE_WORDS];
    logic [K_W-1:0] val_cnt_reg, val_cnt_next;
    logic           val_end_reg, val_end_next;
    logic           val_tl_reg, val_tl_next;

    logic miss_reg, miss_next;
    logic store_ok_reg, store_ok_next;

    logic             valid_reg [ENTRIES];
    logic             valid_next [ENTRIES];
    logic [IDX_W-1:0] rank_reg [ENTRIES];
    logic [IDX_W-1:0] rank_next [ENTRIES];
    logic [SUM_W-1:0] cs_reg [ENTRIES];

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             len_done_reg, len_done_next;
    logic [MC_W-1:0]  mc_reg;

    logic [63:0] key_mem [ENTRIES * KEY_WORDS];
    logic [63:0] val_mem [ENTRIES * VALUE_WORDS];
    logic [63:0] key_rd_reg, val_rd_reg;
    logic [KADDR_W-1:0] key_addr;
    logic [VADDR_W-1:0] val_addr;

    logic        out_valid_reg;
    logic [71:0] out_data_reg;
    logic [1:0]  out_user_reg;
    logic        out_last_reg;

    // word capture
    logic [3:0]  in_fz;
    logic [63:0] in_masked;
    logic [10:0] in_bsum;
    logic [63:0] key_sel, val_sel;

    // result shaping
    logic [MC_W-1:0] mc_eff;
    logic [7:0]      vis, n_words, k8, keep;
    logic [5:0]      len_out;
    logic [3:0]      rd_fz;
    logic            out_free;

    assign in_fz     = first_zero(s_tdata);
    assign in_masked = keep_bytes(s_tdata, {4'd0, in_fz});

    always_comb begin
        in_bsum = '0;
        for (int b = 0; b < 8; b++) in_bsum = in_bsum + 11'(in_masked[8*b +: 8]);
    end

    always_comb begin
        key_sel = '0;
        for (int i = 0; i < KEY_WORDS; i++) begin
            if (k_reg == K_W'(i)) key_sel = key_buf_reg[i];
        end
        val_sel = '0;
        for (int i = 0; i < VALUE_WORDS; i++) begin
            if (k_reg == K_W'(i)) val_sel = val_buf_reg[i];
        end
    end

    assign key_addr = KADDR_W'(KADDR_W'(idx_reg) * KADDR_W'(KEY_WORDS)) + KADDR_W'(k_reg);
    assign val_addr = VADDR_W'(VADDR_W'(idx_reg) * VADDR_W'(VALUE_WORDS)) + VADDR_W'(k_reg);

    always_comb begin
        if (mc_reg == '0) mc_eff = MC_W'(1);
        else if (mc_reg > MC_W'(MC_MAX)) mc_eff = MC_W'(MC_MAX);
        else mc_eff = mc_reg;
        vis     = (8'(len_reg) < 8'(mc_eff)) ? 8'(len_reg) : 8'(mc_eff);
        n_words = (vis == 8'd0) ? 8'd1 : ((vis + 8'd7) >> 3);
        k8      = 8'(k_reg) << 3;
        keep    = (vis > k8) ? (vis - k8) : 8'd0;
        len_out = (8'(len_reg) < 8'(mc_eff)) ? 6'(len_reg) : 6'(mc_eff - MC_W'(1));
    end

    assign rd_fz    = first_zero(val_rd_reg);
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        logic [IDX_W-1:0] r;
        kind_next     = kind_reg;
        last_next     = last_reg;
        key_buf_next  = key_buf_reg;
        key_cnt_next  = key_cnt_reg;
        key_end_next  = key_end_reg;
        key_tl_next   = key_tl_reg;
        key_cmp_next  = key_cmp_reg;
        sum_next      = sum_reg;
        val_buf_next  = val_buf_reg;
        val_cnt_next  = val_cnt_reg;
        val_end_next  = val_end_reg;
        val_tl_next   = val_tl_reg;
        miss_next     = miss_reg;
        store_ok_next = store_ok_reg;
        valid_next    = valid_reg;
        rank_next     = rank_reg;
        idx_next      = idx_reg;
        k_next        = k_reg;
        len_next      = len_reg;
        len_done_next = len_done_reg;
        r             = rank_reg[idx_reg];

        if (cmd.take) begin
            kind_next = s_tuser;
            last_next = s_tlast;
            if (s_tuser == KIND_KEY) begin
                miss_next = 1'b0;
                for (int i = 0; i < VALUE_WORDS; i++) val_buf_next[i] = '0;
                val_cnt_next = '0;
                val_end_next = 1'b0;
                val_tl_next  = 1'b0;
                if (key_cmp_reg) begin
                    for (int i = 0; i < KEY_WORDS; i++) key_buf_next[i] = '0;
                    key_cnt_next = '0;
                    key_end_next = 1'b0;
                    key_tl_next  = 1'b0;
                    sum_next     = '0;
                end
                if (!key_end_next) begin
                    if (key_cnt_next >= K_W'(KEY_WORDS)) begin
                        if (s_tdata[7:0] != 8'd0) key_tl_next = 1'b1;
                        key_end_next = 1'b1;
                    end else begin
                        for (int i = 0; i < KEY_WORDS; i++) begin
                            if (key_cnt_next == K_W'(i)) key_buf_next[i] = in_masked;
                        end
                        key_cnt_next = key_cnt_next + K_W'(1);
                        key_end_next = (in_fz != 4'd8);
                        sum_next     = sum_next + SUM_W'(in_bsum);
                    end
                end
                key_cmp_next = s_tlast;
            end else if (s_tuser == KIND_FILL) begin
                if (!val_end_reg) begin
                    if (val_cnt_reg >= K_W'(VALUE_WORDS)) begin
                        if (s_tdata[7:0] != 8'd0) val_tl_next = 1'b1;
                        val_end_next = 1'b1;
                    end else begin
                        for (int i = 0; i < VALUE_WORDS; i++) begin
                            if (val_cnt_reg == K_W'(i)) val_buf_next[i] = in_masked;
                        end
                        val_cnt_next = val_cnt_reg + K_W'(1);
                        val_end_next = (in_fz != 4'd8);
                    end
                end
            end else if (s_tuser == KIND_CLEAR) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    valid_next[i] = 1'b0;
                    rank_next[i]  = IDX_W'(ENTRIES - 1 - i);
                end
                for (int i = 0; i < KEY_WORDS; i++) key_buf_next[i] = '0;
                key_cnt_next = '0;
                key_end_next = 1'b0;
                key_tl_next  = 1'b0;
                key_cmp_next = 1'b0;
                sum_next     = '0;
                for (int i = 0; i < VALUE_WORDS; i++) val_buf_next[i] = '0;
                val_cnt_next = '0;
                val_end_next = 1'b0;
                val_tl_next  = 1'b0;
                miss_next    = 1'b0;
            end
        end

        if (cmd.idx_rst) idx_next = '0;
        if (cmd.idx_inc) idx_next = idx_reg + IDX_W'(1);
        if (cmd.k_rst)   k_next = '0;
        if (cmd.k_inc)   k_next = k_reg + K_W'(1);
        if (cmd.len_rst) begin
            len_next      = '0;
            len_done_next = 1'b0;
        end
        if (cmd.len_acc && !len_done_reg) begin
            len_next      = len_reg + LEN_W'(rd_fz);
            len_done_next = (rd_fz != 4'd8);
        end

        if (cmd.promote || cmd.commit) begin
            for (int j = 0; j < ENTRIES; j++) begin
                if (rank_reg[j] < r) rank_next[j] = rank_reg[j] + IDX_W'(1);
            end
            rank_next[idx_reg] = '0;
        end
        if (cmd.commit) begin
            valid_next[idx_reg] = 1'b1;
            store_ok_next       = 1'b1;
        end
        if (cmd.emit_miss) miss_next = 1'b1;
        if (cmd.emit_ack) begin
            miss_next     = 1'b0;
            store_ok_next = 1'b0;
            for (int i = 0; i < VALUE_WORDS; i++) val_buf_next[i] = '0;
            val_cnt_next = '0;
            val_end_next = 1'b0;
            val_tl_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg     <= KIND_KEY;
            last_reg     <= 1'b0;
            for (int i = 0; i < KEY_WORDS; i++) key_buf_reg[i] <= '0;
            key_cnt_reg  <= '0;
            key_end_reg  <= 1'b0;
            key_tl_reg   <= 1'b0;
            key_cmp_reg  <= 1'b0;
            sum_reg      <= '0;
            for (int i = 0; i < VALUE_WORDS; i++) val_buf_reg[i] <= '0;
            val_cnt_reg  <= '0;
            val_end_reg  <= 1'b0;
            val_tl_reg   <= 1'b0;
            miss_reg     <= 1'b0;
            store_ok_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= IDX_W'(ENTRIES - 1 - i);
            end
            idx_reg      <= '0;
            k_reg        <= '0;
            len_reg      <= '0;
            len_done_reg <= 1'b0;
            mc_reg       <= MC_W'(MC_RESET);
            out_valid_reg <= 1'b0;
        end else begin
            kind_reg     <= kind_next;
            last_reg     <= last_next;
            key_buf_reg  <= key_buf_next;
            key_cnt_reg  <= key_cnt_next;
            key_end_reg  <= key_end_next;
            key_tl_reg   <= key_tl_next;
            key_cmp_reg  <= key_cmp_next;
            sum_reg      <= sum_next;
            val_buf_reg  <= val_buf_next;
            val_cnt_reg  <= val_cnt_next;
            val_end_reg  <= val_end_next;
            val_tl_reg   <= val_tl_next;
            miss_reg     <= miss_next;
            store_ok_reg <= store_ok_next;
            valid_reg    <= valid_next;
            rank_reg     <= rank_next;
            idx_reg      <= idx_next;
            k_reg        <= k_next;
            len_reg      <= len_next;
            len_done_reg <= len_done_next;
            if (cfg_we) mc_reg <= cfg_data;
            if (cmd.emit_hit || cmd.emit_miss || cmd.emit_ack) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: word, length, stored, pad
    always_ff @(posedge aclk) begin
        if (cmd.emit_hit) begin
            out_data_reg <= {1'b0, 1'b0, len_out, keep_bytes(val_rd_reg, keep)};
            out_user_reg <= RES_HIT;
            out_last_reg <= (k_reg == K_W'(n_words - 8'd1));
        end else if (cmd.emit_miss) begin
            out_data_reg <= '0;
            out_user_reg <= RES_MISS;
            out_last_reg <= 1'b1;
        end else if (cmd.emit_ack) begin
            out_data_reg <= {1'b0, store_ok_reg, 70'd0};
            out_user_reg <= RES_ACK;
            out_last_reg <= 1'b1;
        end
        if (cmd.commit) cs_reg[idx_reg] <= sum_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_word && k_reg < K_W'(KEY_WORDS)) key_mem[key_addr] <= key_sel;
        key_rd_reg <= key_mem[key_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_word && k_reg < K_W'(VALUE_WORDS)) val_mem[val_addr] <= val_sel;
        val_rd_reg <= val_mem[val_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    assign sts.kind        = kind_reg;
    assign sts.last        = last_reg;
    assign sts.key_tl      = key_tl_reg;
    assign sts.fill_ok     = miss_reg && !key_tl_reg && !val_tl_reg;
    assign sts.cand        = valid_reg[idx_reg] && (cs_reg[idx_reg] == sum_reg);
    assign sts.idx_last    = (idx_reg == IDX_W'(ENTRIES - 1));
    assign sts.key_eq      = (key_rd_reg == key_sel);
    assign sts.k_last_key  = (k_reg == K_W'(KEY_WORDS - 1));
    assign sts.k_last_val  = (k_reg == K_W'(VALUE_WORDS - 1));
    assign sts.k_last_emit = (k_reg == K_W'(n_words - 8'd1));
    assign sts.k_last_wr   = (k_reg == K_W'(KMAX - 1));
    assign sts.rank_oldest = (rank_reg[idx_reg] == IDX_W'(ENTRIES - 1));
    assign sts.out_free    = out_free;

endmodule

// File: design/lru_name_cache.sv
// Top level of the fully associative LRU name cache.
// Depends on lnc_pkg, lnc_ctrl and lnc_dp.
//
//  channel | direction | tdata                                   | tuser  | tlast
//  s_      | in        | word[63:0]                              | kind   | last
//  m_      | out       | word_res[63:0] length[69:64] stored[70] | status | last_res
//  cfg_    | in        | max_chars[6:0] (cfg_data)               | -      | -
//
// Every transaction on s_ is accepted, then dispatched. A lookup on its last
// key word then scans the entries in turn, compares up to KEY_WORDS key words
// of each entry whose checksum matches, reads the VALUE_WORDS value words to
// measure the value length and reads each result word; the key and the value
// memory each have a single read port. A storing fill searches up to ENTRIES
// entries for a victim, writes KMAX words and then sends the acknowledgment.
// Reset: aresetn synchronous active low; entry valid bits clear at once, so
// no clearing pass is needed. A stalled m_ holds the controller only when it
// has a further result to load; new input is taken while a result waits.
module lru_name_cache (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // word
    input  logic [1:0]  s_tuser,   // kind
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // word_res, length, stored, zero pad
    output logic [1:0]  m_tuser,   // status
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);
    import lnc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // configuration is to be written only while idle by the user (unenforced by the block), so always take it
    assign cfg_ready = 1'b1;

    lnc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lnc_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data)
    );

`ifndef SYNTHESIS
    // a result is loaded only into a free output register
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_hit || cmd.emit_miss || cmd.emit_ack) |-> sts.out_free)
        else $error("result loaded over a waiting result");

    // one transaction at a time: ready drops after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while previous one is in progress");

    // no result is produced in the cycle an input is taken
    a_no_emit_on_take: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |-> !(cmd.emit_hit || cmd.emit_miss || cmd.emit_ack))
        else $error("result emitted in accept cycle");
`endif

endmodule
